// ----- hdl/awf_pkg.sv -----
// Package for the ALU with flags and branch test.
// Holds opcodes, widths, branch conditions and the opcode class type; depends on nothing.
package awf_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ImmWidth  = 9;
  localparam int unsigned OpWidth   = 5;

  localparam logic [OpWidth-1:0] OpNop    = 5'd0;
  localparam logic [OpWidth-1:0] OpAdd    = 5'd1;
  localparam logic [OpWidth-1:0] OpSub    = 5'd2;
  localparam logic [OpWidth-1:0] OpLsr    = 5'd3;
  localparam logic [OpWidth-1:0] OpLsl    = 5'd4;
  localparam logic [OpWidth-1:0] OpRsr    = 5'd5;
  localparam logic [OpWidth-1:0] OpMov    = 5'd6;
  localparam logic [OpWidth-1:0] OpMul    = 5'd7;
  localparam logic [OpWidth-1:0] OpDiv    = 5'd8;
  localparam logic [OpWidth-1:0] OpMod    = 5'd9;
  localparam logic [OpWidth-1:0] OpAnd    = 5'd10;
  localparam logic [OpWidth-1:0] OpOr     = 5'd11;
  localparam logic [OpWidth-1:0] OpXor    = 5'd12;
  localparam logic [OpWidth-1:0] OpNot    = 5'd13;
  localparam logic [OpWidth-1:0] OpCmp    = 5'd14;
  localparam logic [OpWidth-1:0] OpInc    = 5'd15;
  localparam logic [OpWidth-1:0] OpDec    = 5'd16;
  localparam logic [OpWidth-1:0] OpBranch = 5'd18;
  localparam logic [OpWidth-1:0] OpIdle   = 5'd19;

  localparam logic [1:0] CondZero     = 2'd0;
  localparam logic [1:0] CondNegative = 2'd1;
  localparam logic [1:0] CondCarry    = 2'd2;
  localparam logic [1:0] CondOverflow = 2'd3;

  // Classes assigned by the front end.
  typedef enum logic [1:0] {
    ClsSimple = 2'd0,
    ClsDivide = 2'd1,
    ClsBranch = 2'd2,
    ClsIdle   = 2'd3
  } cls_e;

endpackage

// ----- hdl/awf_front.sv -----
// Front end: accepts requests, selects operand B and classifies the opcode.
// Depends on awf_pkg.
module awf_front #(
  parameter int unsigned DATA_WIDTH = awf_pkg::DataWidth,
  parameter int unsigned IMM_WIDTH  = awf_pkg::ImmWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [awf_pkg::OpWidth-1:0] operation_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] register_operand_i,
  input  logic                        use_immediate_i,
  input  logic signed [IMM_WIDTH-1:0] immediate_i,
  input  logic [1:0]                  branch_condition_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output logic [awf_pkg::OpWidth-1:0] q_op_o,
  output awf_pkg::cls_e               q_cls_o,
  output logic [DATA_WIDTH-1:0]       q_a_o,
  output logic [DATA_WIDTH-1:0]       q_b_o,
  output logic [1:0]                  q_cond_o
);

  // Two-entry queue.
  logic [1:0]                  vld_q, vld_d;
  logic                        wr_q, rd_q;
  logic [awf_pkg::OpWidth-1:0] op_q   [2];
  awf_pkg::cls_e               cls_q  [2];
  logic [DATA_WIDTH-1:0]       a_q    [2];
  logic [DATA_WIDTH-1:0]       b_q    [2];
  logic [1:0]                  cond_q [2];
  logic [DATA_WIDTH-1:0]       b_sel;
  awf_pkg::cls_e               cls;
  logic                        push, pop;

  always_comb begin
    // The signed immediate is sign-extended or wrapped to the data width.
    if (use_immediate_i) begin
      b_sel = DATA_WIDTH'(immediate_i);
    end else begin
      b_sel = register_operand_i;
    end
    case (operation_i)
      awf_pkg::OpDiv, awf_pkg::OpMod: cls = awf_pkg::ClsDivide;
      awf_pkg::OpBranch:              cls = awf_pkg::ClsBranch;
      awf_pkg::OpIdle:                cls = awf_pkg::ClsIdle;
      default:                        cls = awf_pkg::ClsSimple;
    endcase
  end

  assign in_ready  = !vld_q[wr_q];
  assign push      = in_valid && in_ready;
  assign q_valid_o = vld_q[rd_q];
  assign pop       = q_valid_o && q_ready_i;
  assign q_op_o    = op_q[rd_q];
  assign q_cls_o   = cls_q[rd_q];
  assign q_a_o     = a_q[rd_q];
  assign q_b_o     = b_q[rd_q];
  assign q_cond_o  = cond_q[rd_q];

  always_comb begin
    vld_d = vld_q;
    if (push) begin
      vld_d[wr_q] = 1'b1;
    end
    if (pop) begin
      vld_d[rd_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_q]   <= operation_i;
      cls_q[wr_q]  <= cls;
      a_q[wr_q]    <= operand_a_i;
      b_q[wr_q]    <= b_sel;
      cond_q[wr_q] <= branch_condition_i;
    end
  end

endmodule

// ----- hdl/awf_divider.sv -----
// Restoring divider for signed truncating division, one quotient bit a cycle.
// Depends on awf_pkg for its default width.
module awf_divider #(
  parameter int unsigned DATA_WIDTH = awf_pkg::DataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] quot_o,
  output logic [DATA_WIDTH-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH + 1);

  logic                  busy_q;
  logic [CntW-1:0]       cnt_q;
  logic [DATA_WIDTH-1:0] dvd_q, dvs_q, rem_q;
  logic                  qneg_q, rneg_q;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH-1:0] abs_a, abs_b;

  assign abs_a   = a_i[DATA_WIDTH-1] ? DATA_WIDTH'(-a_i) : a_i;
  assign abs_b   = b_i[DATA_WIDTH-1] ? DATA_WIDTH'(-b_i) : b_i;
  assign shifted = {rem_q, dvd_q[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DATA_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= abs_a;
      dvs_q  <= abs_b;
      rem_q  <= '0;
      qneg_q <= a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      rneg_q <= a_i[DATA_WIDTH-1];
    end else if (busy_q) begin
      if (!trial[DATA_WIDTH]) begin
        rem_q <= trial[DATA_WIDTH-1:0];
        dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_WIDTH-1:0];
        dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot_o = qneg_q ? DATA_WIDTH'(-dvd_q) : dvd_q;
  assign rem_o  = rneg_q ? DATA_WIDTH'(-rem_q) : rem_q;

endmodule

// ----- hdl/awf_back.sv -----
// Back end: executes queued requests, holds accumulator and flags.
// Depends on awf_pkg and awf_divider.
module awf_back #(
  parameter int unsigned DATA_WIDTH = awf_pkg::DataWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [awf_pkg::OpWidth-1:0] q_op_i,
  input  awf_pkg::cls_e               q_cls_i,
  input  logic [DATA_WIDTH-1:0]       q_a_i,
  input  logic [DATA_WIDTH-1:0]       q_b_i,
  input  logic [1:0]                  q_cond_i,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DATA_WIDTH-1:0]       result_o,
  output logic                        zero_out_o,
  output logic                        negative_out_o,
  output logic                        carry_out_o,
  output logic                        overflow_out_o,
  output logic                        take_jump_o
);

  localparam int unsigned ShW = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StDiv  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [DATA_WIDTH-1:0] acc_q;
  logic                  z_q, n_q, c_q, v_q;
  logic [DATA_WIDTH-1:0] a_q, b_q;
  logic [awf_pkg::OpWidth-1:0] op_q;
  logic signed [2*DATA_WIDTH-1:0] prod_q;
  logic                  jump_q;

  logic [DATA_WIDTH-1:0] r;
  logic                  z, n, c, v, upd;
  logic [DATA_WIDTH:0]   sum, dif;
  logic                  big;
  logic [ShW-1:0]        sh;
  logic [DATA_WIDTH-1:0] minv;
  logic                  div_start, div_done;
  logic [DATA_WIDTH-1:0] quot, rem;
  logic                  sel_flag;

  assign minv = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  assign sh   = q_b_i[ShW-1:0];
  assign big  = (q_b_i >= DATA_WIDTH'(DATA_WIDTH));
  assign sum  = {1'b0, q_a_i} + {1'b0, q_b_i};
  assign dif  = {q_a_i[DATA_WIDTH-1], q_a_i} - {q_b_i[DATA_WIDTH-1], q_b_i};

  assign q_ready_o = (state_q == StIdle);
  assign div_start = q_valid_i && q_ready_o && (q_cls_i == awf_pkg::ClsDivide);

  awf_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (q_a_i),
    .b_i    (q_b_i),
    .done_o (div_done),
    .quot_o (quot),
    .rem_o  (rem)
  );

  always_comb begin
    case (q_cond_i)
      awf_pkg::CondZero:     sel_flag = z_q;
      awf_pkg::CondNegative: sel_flag = n_q;
      awf_pkg::CondCarry:    sel_flag = c_q;
      default:               sel_flag = v_q;
    endcase
  end

  // Combinational results of the simple operations, evaluated on the queue head.
  always_comb begin
    r = acc_q;
    z = 1'b0;
    n = 1'b0;
    c = 1'b0;
    v = 1'b0;
    case (q_op_i)
      awf_pkg::OpNop: r = acc_q;
      awf_pkg::OpAdd: begin
        r = sum[DATA_WIDTH-1:0];
        c = sum[DATA_WIDTH];
        v = (q_a_i[DATA_WIDTH-1] == q_b_i[DATA_WIDTH-1]) &&
            (r[DATA_WIDTH-1] != q_a_i[DATA_WIDTH-1]);
      end
      awf_pkg::OpSub: begin
        r = dif[DATA_WIDTH-1:0];
        c = dif[DATA_WIDTH];
        v = (q_a_i[DATA_WIDTH-1] != q_b_i[DATA_WIDTH-1]) &&
            (r[DATA_WIDTH-1] != q_a_i[DATA_WIDTH-1]);
      end
      awf_pkg::OpLsr: begin
        c = q_a_i[0];
        r = big ? '0 : (q_a_i >> sh);
      end
      awf_pkg::OpLsl: r = big ? '0 : (q_a_i << sh);
      awf_pkg::OpRsr: begin
        c = q_a_i[0];
        r = big ? {DATA_WIDTH{q_a_i[DATA_WIDTH-1]}}
                : DATA_WIDTH'($signed(q_a_i) >>> sh);
      end
      awf_pkg::OpMov: r = q_b_i;
      awf_pkg::OpAnd: r = q_a_i & q_b_i;
      awf_pkg::OpOr:  r = q_a_i | q_b_i;
      awf_pkg::OpXor: r = q_a_i ^ q_b_i;
      awf_pkg::OpNot: begin
        r = ~q_b_i;
        v = (q_b_i == minv);
      end
      awf_pkg::OpCmp: begin
        r = q_a_i;
        n = dif[DATA_WIDTH];
        z = (q_a_i == q_b_i);
      end
      awf_pkg::OpInc: r = q_a_i + 1'b1;
      awf_pkg::OpDec: r = q_a_i - 1'b1;
      default:        r = '1;
    endcase
    if (r == '0) begin
      z = 1'b1;
    end else if ((q_op_i == awf_pkg::OpSub || q_op_i == awf_pkg::OpDec) &&
                 ($signed(r) > $signed(q_a_i))) begin
      n = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    upd     = 1'b0;
    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          case (q_cls_i)
            awf_pkg::ClsDivide: state_d = StDiv;
            awf_pkg::ClsSimple: begin
              state_d = (q_op_i == awf_pkg::OpMul) ? StMul : StOut;
              upd     = (q_op_i != awf_pkg::OpMul);
            end
            default: state_d = StOut;
          endcase
        end
      end
      StMul:   state_d = StOut;
      StDiv:   if (div_done) state_d = StOut;
      StOut:   if (out_ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign out_valid = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      acc_q   <= '0;
      z_q     <= 1'b0;
      n_q     <= 1'b0;
      c_q     <= 1'b0;
      v_q     <= 1'b0;
      jump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && q_valid_i) begin
        jump_q <= (q_cls_i == awf_pkg::ClsBranch) ? sel_flag : 1'b0;
      end
      if (upd) begin
        acc_q <= r;
        z_q   <= z;
        n_q   <= n;
        c_q   <= c;
        v_q   <= v;
      end else if (state_q == StMul) begin
        acc_q <= prod_q[DATA_WIDTH-1:0];
        z_q   <= (prod_q[DATA_WIDTH-1:0] == '0);
        n_q   <= 1'b0;
        c_q   <= 1'b0;
        v_q   <= (prod_q[2*DATA_WIDTH-1:DATA_WIDTH-1] != '0) &&
                 (prod_q[2*DATA_WIDTH-1:DATA_WIDTH-1] != '1);
      end else if (state_q == StDiv && div_done) begin
        c_q <= 1'b0;
        n_q <= 1'b0;
        if (b_q == '0) begin
          v_q <= 1'b1;
          z_q <= (acc_q == '0);
        end else begin
          v_q <= (a_q == minv) && (b_q == '1);
          if (op_q == awf_pkg::OpDiv) begin
            acc_q <= quot;
            z_q   <= (quot == '0);
          end else begin
            acc_q <= rem;
            z_q   <= (rem == '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) begin
      a_q    <= q_a_i;
      b_q    <= q_b_i;
      op_q   <= q_op_i;
      prod_q <= $signed(q_a_i) * $signed(q_b_i);
    end
  end

  assign result_o       = acc_q;
  assign zero_out_o     = z_q;
  assign negative_out_o = n_q;
  assign carry_out_o    = c_q;
  assign overflow_out_o = v_q;
  assign take_jump_o    = jump_q;

endmodule

// ----- hdl/alu_with_flags_and_branch_test.sv -----
// Top level of the ALU with status flags and branch test.
// Depends on awf_pkg, awf_front and awf_back.
//
// Usage: requests enter on the in_valid/in_ready channel with an opcode,
// operand A, a register operand or 9-bit immediate for operand B and a
// branch condition. Each request yields exactly one result on the
// out_valid/out_ready channel: the accumulator and four flags after the
// step, plus take_jump for a branch test.
// The front end classifies requests and places them in a two-entry queue,
// so it can take up to two requests while the back end is busy or stalled.
// Most operations are computed combinationally on the queue head and
// registered into the accumulator and flags. Multiply first registers its
// product in the StMul state. Divide and modulo run a restoring divider,
// one quotient bit per cycle, and wait in the StDiv state until it is done;
// the divider sets the sustained rate for those opcodes.
// The back end handles one request at a time; a result waits in the output
// registers while the receiver stalls, and the queue absorbs new requests.
// Reset clears the accumulator, all flags and the queue.
module alu_with_flags_and_branch_test #(
  parameter int unsigned DATA_WIDTH = awf_pkg::DataWidth,
  parameter int unsigned IMM_WIDTH  = awf_pkg::ImmWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [awf_pkg::OpWidth-1:0]  operation_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] register_operand_i,
  input  logic                         use_immediate_i,
  input  logic signed [IMM_WIDTH-1:0]  immediate_i,
  input  logic [1:0]                   branch_condition_i,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic                         zero_out_o,
  output logic                         negative_out_o,
  output logic                         carry_out_o,
  output logic                         overflow_out_o,
  output logic                         take_jump_o
);

  // Queue head signals between front and back.
  logic                        q_valid, q_ready;
  logic [awf_pkg::OpWidth-1:0] q_op;
  awf_pkg::cls_e               q_cls;
  logic [DATA_WIDTH-1:0]       q_a, q_b;
  logic [1:0]                  q_cond;
  logic [DATA_WIDTH-1:0]       res;

  awf_front #(.DATA_WIDTH(DATA_WIDTH), .IMM_WIDTH(IMM_WIDTH)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation_i       (operation_i),
    .operand_a_i       (operand_a_i),
    .register_operand_i(register_operand_i),
    .use_immediate_i   (use_immediate_i),
    .immediate_i       (immediate_i),
    .branch_condition_i(branch_condition_i),
    .q_valid_o         (q_valid),
    .q_ready_i         (q_ready),
    .q_op_o            (q_op),
    .q_cls_o           (q_cls),
    .q_a_o             (q_a),
    .q_b_o             (q_b),
    .q_cond_o          (q_cond)
  );

  awf_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_op_i        (q_op),
    .q_cls_i       (q_cls),
    .q_a_i         (q_a),
    .q_b_i         (q_b),
    .q_cond_i      (q_cond),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_o      (res),
    .zero_out_o    (zero_out_o),
    .negative_out_o(negative_out_o),
    .carry_out_o   (carry_out_o),
    .overflow_out_o(overflow_out_o),
    .take_jump_o   (take_jump_o)
  );

  assign result_o = res;

endmodule
